/* src/rsc_pkg.sv */
// rsc_pkg: shared types, constants and helper functions of the rabbit cipher block
// used by rsc_ctrl, rsc_datapath and rabbit_stream_cipher_top; no dependencies
package rsc_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NWORDS   = 8;
    localparam int unsigned CFG_W    = 64;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned NB_W     = 5;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned ITER_W   = 2;
    localparam int unsigned SETUP_ITERS = 4;
    localparam logic [NB_W-1:0] FULL_BLOCK = NB_W'(16);

    localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
    localparam logic [OP_W-1:0] OP_IV    = 2'd1;
    localparam logic [OP_W-1:0] OP_CRYPT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV       = 2'd2;

    localparam logic [WORD_W-1:0] STEP_A = 32'h4D34D34D;
    localparam logic [WORD_W-1:0] STEP_B = 32'hD34D34D3;
    localparam logic [WORD_W-1:0] STEP_C = 32'h34D34D34;
    localparam logic [WORD_W-1:0] MASK_HI = 32'hFFFF0000;
    localparam logic [WORD_W-1:0] MASK_LO = 32'h0000FFFF;

    // counter increments, word 0 in the low bits
    localparam logic [NWORDS*WORD_W-1:0] STEP_VEC =
        {STEP_B, STEP_A, STEP_C, STEP_B, STEP_A, STEP_C, STEP_B, STEP_A};

    typedef struct packed {
        logic load_in;
        logic key_load;
        logic iv_load;
        logic use_master;
        logic cnt_step;
        logic sq_step;
        logic mix_step;
        logic key_fold;
        logic out_load;
        logic out_crypt;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

    function automatic logic [WORD_W-1:0] rot16(input logic [WORD_W-1:0] v);
        rot16 = {v[15:0], v[31:16]};
    endfunction

    function automatic logic [WORD_W-1:0] rot8(input logic [WORD_W-1:0] v);
        rot8 = {v[23:0], v[31:24]};
    endfunction

    // square and fold the product halves together
    function automatic logic [WORD_W-1:0] gfold(input logic [WORD_W-1:0] v);
        logic [2*WORD_W-1:0] sq;
        sq = {{WORD_W{1'b0}}, v} * {{WORD_W{1'b0}}, v};
        gfold = sq[63:32] ^ sq[31:0];
    endfunction

endpackage

/* src/rsc_ctrl.sv */
// rsc_ctrl: sequencer of the rabbit cipher block, drives rsc_datapath commands
// depends on rsc_pkg
module rsc_ctrl
    import rsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [NB_W-1:0]     i_valid_bytes,
    output logic                o_ready,
    input  t_dp_stat            i_stat,
    output t_dp_cmd             o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT,
        S_SQ,
        S_MIX,
        S_FOLD,
        S_OUT
    } t_state;

    t_state               r_state, n_state;
    logic [OP_W-1:0]      r_op, n_op;
    logic [ITER_W-1:0]    r_iter, n_iter;
    logic                 r_crypt, n_crypt;
    logic                 w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_iter  = r_iter;
        n_crypt = r_crypt;
        o_cmd   = '0;
        o_cmd.use_master = (r_op == OP_KEY);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_in = 1'b1;
                    n_op    = i_opcode;
                    n_crypt = 1'b0;
                    case (i_opcode)
                        OP_KEY: begin
                            o_cmd.key_load = 1'b1;
                            n_iter  = ITER_W'(SETUP_ITERS - 1);
                            n_state = S_CNT;
                        end
                        OP_IV: begin
                            o_cmd.iv_load = 1'b1;
                            n_iter  = ITER_W'(SETUP_ITERS - 1);
                            n_state = S_CNT;
                        end
                        OP_CRYPT: begin
                            n_iter = '0;
                            if (i_valid_bytes != '0) begin
                                n_crypt = 1'b1;
                                n_state = S_CNT;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_CNT: begin
                o_cmd.cnt_step = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                n_state = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix_step = 1'b1;
                if (r_iter != '0) begin
                    n_iter  = r_iter - 1'b1;
                    n_state = S_CNT;
                end else if (r_op == OP_KEY) begin
                    n_state = S_FOLD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FOLD: begin
                o_cmd.key_fold = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_crypt = r_crypt;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_CRYPT;
            r_iter  <= '0;
            r_crypt <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_iter  <= n_iter;
            r_crypt <= n_crypt;
        end
    end

endmodule

/* src/rsc_datapath.sv */
// rsc_datapath: key/iv registers, master and work state, shared advance unit,
// keystream xor and output register; depends on rsc_pkg
module rsc_datapath
    import rsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [WORD_W-1:0]    i_data_word0,
    input  logic [WORD_W-1:0]    i_data_word1,
    input  logic [WORD_W-1:0]    i_data_word2,
    input  logic [WORD_W-1:0]    i_data_word3,
    input  logic [NB_W-1:0]      i_valid_bytes,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [WORD_W-1:0]    o_out_word0,
    output logic [WORD_W-1:0]    o_out_word1,
    output logic [WORD_W-1:0]    o_out_word2,
    output logic [WORD_W-1:0]    o_out_word3
);

    localparam int unsigned VEC_W = NWORDS * WORD_W;

    logic [CFG_W-1:0]  r_key_low, r_key_high, r_iv;
    logic [WORD_W-1:0] r_mx [NWORDS];
    logic [WORD_W-1:0] r_mc [NWORDS];
    logic              r_mcarry;
    logic [WORD_W-1:0] r_wx [NWORDS];
    logic [WORD_W-1:0] r_wc [NWORDS];
    logic              r_wcarry;
    logic [WORD_W-1:0] r_g  [NWORDS];
    logic [WORD_W-1:0] r_data [4];
    logic [NB_W-1:0]   r_nbytes;
    logic [WORD_W-1:0] r_out [4];
    logic              r_out_valid;

    logic [WORD_W-1:0] w_k [4];
    logic [WORD_W-1:0] w_kx [NWORDS];
    logic [WORD_W-1:0] w_kc [NWORDS];
    logic [WORD_W-1:0] w_iw [4];
    logic [WORD_W-1:0] w_sx [NWORDS];
    logic [WORD_W-1:0] w_sc [NWORDS];
    logic              w_scarry;
    logic [VEC_W-1:0]  w_cvec;
    logic [VEC_W:0]    w_csum;
    logic [WORD_W-1:0] w_cnew [NWORDS];
    logic [WORD_W-1:0] w_gnew [NWORDS];
    logic [WORD_W-1:0] w_xnew [NWORDS];
    logic [WORD_W-1:0] w_ks [4];
    logic [WORD_W-1:0] w_res [4];

    // key expansion into the initial master state, and iv expansion into four words
    always_comb begin
        w_k[0] = r_key_low[31:0];
        w_k[1] = r_key_low[63:32];
        w_k[2] = r_key_high[31:0];
        w_k[3] = r_key_high[63:32];
        w_kx[0] = w_k[0];
        w_kx[2] = w_k[1];
        w_kx[4] = w_k[2];
        w_kx[6] = w_k[3];
        w_kx[1] = {w_k[3][15:0], w_k[2][31:16]};
        w_kx[3] = {w_k[0][15:0], w_k[3][31:16]};
        w_kx[5] = {w_k[1][15:0], w_k[0][31:16]};
        w_kx[7] = {w_k[2][15:0], w_k[1][31:16]};
        w_kc[0] = rot16(w_k[2]);
        w_kc[2] = rot16(w_k[3]);
        w_kc[4] = rot16(w_k[0]);
        w_kc[6] = rot16(w_k[1]);
        w_kc[1] = (w_k[0] & MASK_HI) | (w_k[1] & MASK_LO);
        w_kc[3] = (w_k[1] & MASK_HI) | (w_k[2] & MASK_LO);
        w_kc[5] = (w_k[2] & MASK_HI) | (w_k[3] & MASK_LO);
        w_kc[7] = (w_k[3] & MASK_HI) | (w_k[0] & MASK_LO);
        w_iw[0] = r_iv[31:0];
        w_iw[2] = r_iv[63:32];
        w_iw[1] = {r_iv[63:48], r_iv[31:16]};
        w_iw[3] = {r_iv[47:32], r_iv[15:0]};
    end

    // shared advance unit: counters in one wide add, then squarers, then mix
    always_comb begin
        for (int i = 0; i < NWORDS; i++) begin
            w_sx[i] = i_cmd.use_master ? r_mx[i] : r_wx[i];
            w_sc[i] = i_cmd.use_master ? r_mc[i] : r_wc[i];
            w_cvec[i*WORD_W +: WORD_W] = w_sc[i];
        end
        w_scarry = i_cmd.use_master ? r_mcarry : r_wcarry;
        w_csum = {1'b0, w_cvec} + {1'b0, STEP_VEC} + {{VEC_W{1'b0}}, w_scarry};
        for (int i = 0; i < NWORDS; i++) begin
            w_cnew[i] = w_csum[i*WORD_W +: WORD_W];
            w_gnew[i] = gfold(w_sx[i] + w_sc[i]);
        end
        w_xnew[0] = r_g[0] + rot16(r_g[7]) + rot16(r_g[6]);
        w_xnew[1] = r_g[1] + rot8(r_g[0]) + r_g[7];
        w_xnew[2] = r_g[2] + rot16(r_g[1]) + rot16(r_g[0]);
        w_xnew[3] = r_g[3] + rot8(r_g[2]) + r_g[1];
        w_xnew[4] = r_g[4] + rot16(r_g[3]) + rot16(r_g[2]);
        w_xnew[5] = r_g[5] + rot8(r_g[4]) + r_g[3];
        w_xnew[6] = r_g[6] + rot16(r_g[5]) + rot16(r_g[4]);
        w_xnew[7] = r_g[7] + rot8(r_g[6]) + r_g[5];
    end

    // keystream and byte masking
    always_comb begin
        w_ks[0] = r_wx[0] ^ {16'h0, r_wx[5][31:16]} ^ {r_wx[3][15:0], 16'h0};
        w_ks[1] = r_wx[2] ^ {16'h0, r_wx[7][31:16]} ^ {r_wx[5][15:0], 16'h0};
        w_ks[2] = r_wx[4] ^ {16'h0, r_wx[1][31:16]} ^ {r_wx[7][15:0], 16'h0};
        w_ks[3] = r_wx[6] ^ {16'h0, r_wx[3][31:16]} ^ {r_wx[1][15:0], 16'h0};
        for (int j = 0; j < 4; j++) begin
            for (int b = 0; b < 4; b++) begin
                w_res[j][8*b +: 8] = (NB_W'(4*j + b) < r_nbytes) ?
                    (r_data[j][8*b +: 8] ^ w_ks[j][8*b +: 8]) : 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_iv       <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_IV:       r_iv       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NWORDS; i++) begin
                r_mx[i] <= '0;
                r_mc[i] <= '0;
                r_wx[i] <= '0;
                r_wc[i] <= '0;
            end
            r_mcarry <= 1'b0;
            r_wcarry <= 1'b0;
        end else begin
            if (i_cmd.key_load) begin
                for (int i = 0; i < NWORDS; i++) begin
                    r_mx[i] <= w_kx[i];
                    r_mc[i] <= w_kc[i];
                end
                r_mcarry <= 1'b0;
            end else if (i_cmd.iv_load) begin
                for (int i = 0; i < NWORDS; i++) begin
                    r_wx[i] <= r_mx[i];
                    r_wc[i] <= r_mc[i] ^ w_iw[i % 4];
                end
                r_wcarry <= r_mcarry;
            end else if (i_cmd.cnt_step) begin
                for (int i = 0; i < NWORDS; i++) begin
                    if (i_cmd.use_master) r_mc[i] <= w_cnew[i];
                    else                  r_wc[i] <= w_cnew[i];
                end
                if (i_cmd.use_master) r_mcarry <= w_csum[VEC_W];
                else                  r_wcarry <= w_csum[VEC_W];
            end else if (i_cmd.mix_step) begin
                for (int i = 0; i < NWORDS; i++) begin
                    if (i_cmd.use_master) r_mx[i] <= w_xnew[i];
                    else                  r_wx[i] <= w_xnew[i];
                end
            end else if (i_cmd.key_fold) begin
                // counters are xored with the state word four places on, and work gets a copy of the result
                for (int i = 0; i < NWORDS; i++) begin
                    r_mc[i] <= r_mc[i] ^ r_mx[(i + 4) % NWORDS];
                    r_wc[i] <= r_mc[i] ^ r_mx[(i + 4) % NWORDS];
                    r_wx[i] <= r_mx[i];
                end
                r_wcarry <= r_mcarry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_step) begin
            for (int i = 0; i < NWORDS; i++) begin
                r_g[i] <= w_gnew[i];
            end
        end
        if (i_cmd.load_in) begin
            r_data[0] <= i_data_word0;
            r_data[1] <= i_data_word1;
            r_data[2] <= i_data_word2;
            r_data[3] <= i_data_word3;
            r_nbytes  <= (i_valid_bytes > FULL_BLOCK) ? FULL_BLOCK : i_valid_bytes;
        end
        if (i_cmd.out_load) begin
            for (int j = 0; j < 4; j++) begin
                r_out[j] <= i_cmd.out_crypt ? w_res[j] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_ready;
    assign o_valid     = r_out_valid;
    assign o_out_word0 = r_out[0];
    assign o_out_word1 = r_out[1];
    assign o_out_word2 = r_out[2];
    assign o_out_word3 = r_out[3];

endmodule

/* src/rabbit_stream_cipher_top.sv */
// rabbit_stream_cipher_top: 128-bit key, 64-bit iv rabbit stream cipher
// input channel (opcode, four data words, valid byte count) and output channel
// (four result words), both valid/ready, plus a plain register write port.
// opcode key setup loads key_low/key_high into the master state and runs four
// state iterations; iv setup xors init_vector into a copy of it and runs four;
// crypt runs one iteration and xors the keystream into the block, bytes at or
// beyond valid_bytes read as zero. setup and unknown opcodes return one beat
// of zeros. each iteration of the shared advance unit runs in three steps
// (counter add, eight squarers, mixing adders), and key setup ends with a
// counter fold step. a crypt beat with a zero byte count runs no iteration
// and returns one beat of zeros.
// one item is in work at a time; the next is taken once the result has gone
// into the output register, which holds it while the receiver stalls.
// reset (synchronous, active low) clears key, iv, master and work state.
// the user must write registers only while the block is idle; not enforced.
module rabbit_stream_cipher_top
    import rsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [WORD_W-1:0]    i_data_word0,
    input  logic [WORD_W-1:0]    i_data_word1,
    input  logic [WORD_W-1:0]    i_data_word2,
    input  logic [WORD_W-1:0]    i_data_word3,
    input  logic [NB_W-1:0]      i_valid_bytes,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [WORD_W-1:0]    o_out_word0,
    output logic [WORD_W-1:0]    o_out_word1,
    output logic [WORD_W-1:0]    o_out_word2,
    output logic [WORD_W-1:0]    o_out_word3
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rsc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_opcode      (i_opcode),
        .i_valid_bytes (i_valid_bytes),
        .o_ready       (o_ready),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    rsc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_data_word0  (i_data_word0),
        .i_data_word1  (i_data_word1),
        .i_data_word2  (i_data_word2),
        .i_data_word3  (i_data_word3),
        .i_valid_bytes (i_valid_bytes),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_out_word0   (o_out_word0),
        .o_out_word1   (o_out_word1),
        .o_out_word2   (o_out_word2),
        .o_out_word3   (o_out_word3)
    );

endmodule

/* bench/rsc_tb_checker.sv */
// rsc_tb_checker: watches the register port and both channels of the rabbit cipher block,
// predicts each result beat from its own copy of the cipher state and compares them
// depends on rsc_pkg for widths, opcodes, register indexes and counter step constants
module rsc_tb_checker
    import rsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [WORD_W-1:0]    i_data_word0,
    input  logic [WORD_W-1:0]    i_data_word1,
    input  logic [WORD_W-1:0]    i_data_word2,
    input  logic [WORD_W-1:0]    i_data_word3,
    input  logic [NB_W-1:0]      i_valid_bytes,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [WORD_W-1:0]    i_out_word0,
    input  logic [WORD_W-1:0]    i_out_word1,
    input  logic [WORD_W-1:0]    i_out_word2,
    input  logic [WORD_W-1:0]    i_out_word3,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [3:0][WORD_W-1:0] t_block;

    typedef struct packed {
        logic [7:0][WORD_W-1:0] x;
        logic [7:0][WORD_W-1:0] c;
        logic                   carry;
    } t_cipher_state;

    t_cipher_state master_st;
    t_cipher_state work_st;
    logic [CFG_W-1:0] key_lo_q;
    logic [CFG_W-1:0] key_hi_q;
    logic [CFG_W-1:0] iv_q;

    t_block result_q[$];
    t_block got_blk;
    t_block want_blk;
    int     fail_count = 0;
    int     pending_count = 0;

    assign o_errors  = fail_count;
    assign o_pending = pending_count;

    function automatic t_word rotl(input t_word v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic t_word square_fold(input t_word v);
        logic [2*WORD_W-1:0] p;
        p = 64'(v) * 64'(v);
        return p[63:32] ^ p[31:0];
    endfunction

    // one rabbit iteration: counter chain, then g-function and mixing
    function automatic t_cipher_state iterate(input t_cipher_state s);
        t_cipher_state n;
        logic [WORD_W:0] sum;
        t_word g [8];
        logic cy;
        n  = s;
        cy = s.carry;
        for (int i = 0; i < 8; i++) begin
            sum    = {1'b0, s.c[i]} + {1'b0, STEP_VEC[i*WORD_W +: WORD_W]} + 33'(cy);
            n.c[i] = sum[WORD_W-1:0];
            cy     = sum[WORD_W];
        end
        n.carry = cy;
        for (int i = 0; i < 8; i++)
            g[i] = square_fold(s.x[i] + n.c[i]);
        n.x[0] = g[0] + rotl(g[7], 16) + rotl(g[6], 16);
        n.x[1] = g[1] + rotl(g[0], 8) + g[7];
        n.x[2] = g[2] + rotl(g[1], 16) + rotl(g[0], 16);
        n.x[3] = g[3] + rotl(g[2], 8) + g[1];
        n.x[4] = g[4] + rotl(g[3], 16) + rotl(g[2], 16);
        n.x[5] = g[5] + rotl(g[4], 8) + g[3];
        n.x[6] = g[6] + rotl(g[5], 16) + rotl(g[4], 16);
        n.x[7] = g[7] + rotl(g[6], 8) + g[5];
        return n;
    endfunction

    function automatic t_cipher_state key_schedule(input logic [CFG_W-1:0] lo,
                                                   input logic [CFG_W-1:0] hi);
        t_cipher_state s;
        t_word k0, k1, k2, k3;
        k0 = lo[31:0];
        k1 = lo[63:32];
        k2 = hi[31:0];
        k3 = hi[63:32];
        s.x[0] = k0;
        s.x[2] = k1;
        s.x[4] = k2;
        s.x[6] = k3;
        s.x[1] = {k3[15:0], k2[31:16]};
        s.x[3] = {k0[15:0], k3[31:16]};
        s.x[5] = {k1[15:0], k0[31:16]};
        s.x[7] = {k2[15:0], k1[31:16]};
        s.c[0] = rotl(k2, 16);
        s.c[2] = rotl(k3, 16);
        s.c[4] = rotl(k0, 16);
        s.c[6] = rotl(k1, 16);
        s.c[1] = {k0[31:16], k1[15:0]};
        s.c[3] = {k1[31:16], k2[15:0]};
        s.c[5] = {k2[31:16], k3[15:0]};
        s.c[7] = {k3[31:16], k0[15:0]};
        s.carry = 1'b0;
        for (int i = 0; i < 4; i++)
            s = iterate(s);
        // counters folded with the state word four places on
        for (int i = 0; i < 8; i++)
            s.c[i] ^= s.x[(i + 4) % 8];
        return s;
    endfunction

    function automatic t_cipher_state iv_schedule(input t_cipher_state m,
                                                  input logic [CFG_W-1:0] iv);
        t_cipher_state s;
        t_word ivw [4];
        ivw[0] = iv[31:0];
        ivw[2] = iv[63:32];
        ivw[1] = {iv[63:48], iv[31:16]};
        ivw[3] = {iv[47:32], iv[15:0]};
        s = m;
        for (int i = 0; i < 8; i++)
            s.c[i] ^= ivw[i % 4];
        for (int i = 0; i < 4; i++)
            s = iterate(s);
        return s;
    endfunction

    // updates the cipher state and returns the block this beat should produce
    function automatic t_block predict_block(input logic [OP_W-1:0] op, input t_block data,
                                             input logic [NB_W-1:0] nbytes);
        t_block ks;
        logic [127:0] mask;
        int nb;
        nb   = (nbytes > FULL_BLOCK) ? 16 : int'(nbytes);
        mask = '0;
        case (op)
            OP_KEY: begin
                master_st = key_schedule(key_lo_q, key_hi_q);
                work_st   = master_st;
                return '0;
            end
            OP_IV: begin
                work_st = iv_schedule(master_st, iv_q);
                return '0;
            end
            OP_CRYPT: begin
                if (nb == 0)
                    return '0;
                work_st = iterate(work_st);
                ks[0] = work_st.x[0] ^ (work_st.x[5] >> 16) ^ (work_st.x[3] << 16);
                ks[1] = work_st.x[2] ^ (work_st.x[7] >> 16) ^ (work_st.x[5] << 16);
                ks[2] = work_st.x[4] ^ (work_st.x[1] >> 16) ^ (work_st.x[7] << 16);
                ks[3] = work_st.x[6] ^ (work_st.x[3] >> 16) ^ (work_st.x[1] << 16);
                for (int b = 0; b < 16; b++)
                    if (b < nb)
                        mask[b*8 +: 8] = 8'hFF;
                return (data ^ ks) & mask;
            end
            default: return '0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            master_st = '0;
            work_st   = '0;
            key_lo_q  = '0;
            key_hi_q  = '0;
            iv_q      = '0;
            result_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_KEY_LOW:  key_lo_q = i_cfg_data;
                    REG_KEY_HIGH: key_hi_q = i_cfg_data;
                    REG_IV:       iv_q     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                result_q.push_back(predict_block(i_opcode,
                    {i_data_word3, i_data_word2, i_data_word1, i_data_word0},
                    i_valid_bytes));
            if (i_out_valid && i_out_ready) begin
                got_blk = {i_out_word3, i_out_word2, i_out_word1, i_out_word0};
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, got_blk);
                    fail_count++;
                end else begin
                    want_blk = result_q.pop_front();
                    for (int j = 0; j < 4; j++)
                        if (got_blk[j] !== want_blk[j]) begin
                            $display("%0t: out_word%0d expected %08h got %08h",
                                     $time, j, want_blk[j], got_blk[j]);
                            fail_count++;
                        end
                end
            end
        end
        pending_count = result_q.size();
    end

endmodule

/* bench/testbench.sv */
// testbench: stimulus, register writes and verdict for rabbit_stream_cipher_top
// depends on rsc_pkg, the block itself and rsc_tb_checker, which does the prediction
module testbench
    import rsc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int                   ITEM_TARGET = 1400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [OP_W-1:0]      i_opcode;
    logic [WORD_W-1:0]    i_data_word0;
    logic [WORD_W-1:0]    i_data_word1;
    logic [WORD_W-1:0]    i_data_word2;
    logic [WORD_W-1:0]    i_data_word3;
    logic [NB_W-1:0]      i_valid_bytes;
    logic                 o_valid;
    logic                 i_ready;
    logic [WORD_W-1:0]    o_out_word0;
    logic [WORD_W-1:0]    o_out_word1;
    logic [WORD_W-1:0]    o_out_word2;
    logic [WORD_W-1:0]    o_out_word3;

    int   mismatches;
    int   pending_beats;
    int   items_sent = 0;
    int   rx_beats = 0;
    logic sender_calm = 1'b0;

    rabbit_stream_cipher_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_data_word0  (i_data_word0),
        .i_data_word1  (i_data_word1),
        .i_data_word2  (i_data_word2),
        .i_data_word3  (i_data_word3),
        .i_valid_bytes (i_valid_bytes),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_word0   (o_out_word0),
        .o_out_word1   (o_out_word1),
        .o_out_word2   (o_out_word2),
        .o_out_word3   (o_out_word3)
    );

    rsc_tb_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_opcode      (i_opcode),
        .i_data_word0  (i_data_word0),
        .i_data_word1  (i_data_word1),
        .i_data_word2  (i_data_word2),
        .i_data_word3  (i_data_word3),
        .i_valid_bytes (i_valid_bytes),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_word0   (o_out_word0),
        .i_out_word1   (o_out_word1),
        .i_out_word2   (o_out_word2),
        .i_out_word3   (o_out_word3),
        .o_errors      (mismatches),
        .o_pending     (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("testbench: FAIL");
        $finish;
    end

    always @(posedge i_clk)
        if (o_valid && i_ready)
            rx_beats <= rx_beats + 1;

    // mostly no gap, often a short one, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_W-1:0] reg_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'(1) << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [127:0] rand_block();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic [127:0] blk,
                             input logic [NB_W-1:0] nbytes);
        int gap;
        gap = sender_calm ? 0 : idle_len();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode = op;
        {i_data_word3, i_data_word2, i_data_word1, i_data_word0} = blk;
        i_valid_bytes = nbytes;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // sender stops until every result beat has come back
    task automatic drain();
        i_valid = 1'b0;
        while (pending_beats != 0)
            @(negedge i_clk);
    endtask

    task automatic send_random_crypt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            send_item(OP_CRYPT, rand_block(), FULL_BLOCK);
        else if (r < 92)
            send_item(OP_CRYPT, rand_block(), NB_W'($urandom_range(1, 15)));
        else if (r < 96)
            send_item(OP_CRYPT, rand_block(), '0);
        else
            send_item(OP_CRYPT, rand_block(), NB_W'($urandom_range(17, 31)));
    endtask

    // receiver: random gaps, calm stretches and one long hold-off
    initial begin : sink_proc
        int   gap_left;
        int   calm_left;
        logic held;
        gap_left  = 0;
        calm_left = 0;
        held      = 1'b0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && rx_beats >= 400) begin
                held    = 1'b1;
                i_ready = 1'b0;
                repeat (300) @(negedge i_clk);
            end
            if (gap_left > 0) begin
                i_ready = 1'b0;
                gap_left--;
            end else begin
                i_ready = 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 9) == 0)
                    calm_left = $urandom_range(50, 150);
                else
                    gap_left = idle_len();
            end
        end
    end

    initial begin : stim_proc
        int n_blocks;
        int r;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_opcode      = OP_KEY;
        i_data_word0  = '0;
        i_data_word1  = '0;
        i_data_word2  = '0;
        i_data_word3  = '0;
        i_valid_bytes = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: first with registers still at their reset value of zero, then all ones
        send_item(OP_CRYPT, '0, FULL_BLOCK);
        send_item(OP_KEY, '0, FULL_BLOCK);
        send_item(OP_IV, '0, FULL_BLOCK);
        send_item(OP_CRYPT, '0, FULL_BLOCK);
        send_item(OP_CRYPT, '1, FULL_BLOCK);
        send_item(OP_CRYPT, rand_block(), NB_W'(1));
        send_item(OP_CRYPT, rand_block(), NB_W'(15));
        send_item(OP_CRYPT, rand_block(), '0);
        send_item(OP_CRYPT, rand_block(), NB_W'(17));
        send_item(OP_CRYPT, '1, '1);
        send_item(OP_UNUSED, '1, '1);
        send_item(OP_KEY, '1, '1);
        drain();
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_IV, '1);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        send_item(OP_KEY, '0, FULL_BLOCK);
        send_item(OP_IV, '0, FULL_BLOCK);
        send_item(OP_CRYPT, '0, FULL_BLOCK);
        send_item(OP_CRYPT, '1, FULL_BLOCK);
        send_item(OP_CRYPT, rand_block(), NB_W'(8));
        send_item(OP_IV, '1, '0);
        send_item(OP_CRYPT, rand_block(), FULL_BLOCK);

        // random sessions: new iv and mostly new key registers, key and iv setup, then a run of mostly crypt blocks
        while (items_sent < ITEM_TARGET) begin
            drain();
            if ($urandom_range(0, 3) != 0) begin
                write_reg(REG_KEY_LOW, reg_value());
                write_reg(REG_KEY_HIGH, reg_value());
            end
            write_reg(REG_IV, reg_value());
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, {$urandom, $urandom});
            sender_calm = ($urandom_range(0, 4) == 0);
            send_item(OP_KEY, rand_block(), NB_W'($urandom));
            send_item(OP_IV, rand_block(), NB_W'($urandom));
            n_blocks = $urandom_range(10, 150);
            repeat (n_blocks) begin
                r = $urandom_range(0, 99);
                if (r < 88)
                    send_random_crypt();
                else if (r < 92)
                    send_item(OP_UNUSED, rand_block(), NB_W'($urandom));
                else if (r < 97)
                    send_item(OP_IV, rand_block(), NB_W'($urandom));
                else
                    send_item(OP_KEY, rand_block(), NB_W'($urandom));
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending_beats == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
